FILE: hdl/ptwi_pkg.sv
// Shared constants, types and the arctangent table of the planar twist integrator.
package ptwi_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int WRAP_STEPS        = 14;
   localparam int DIV_STEPS         = 32;

   localparam logic [34:0]        TWO_PI_Q32  = 35'd26986075409;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   typedef struct packed {
      logic               bypass;
      logic               neg_w;
      logic [31:0]        mag_w;
      logic signed [31:0] lin_x;
      logic signed [31:0] lin_y;
      logic signed [18:0] angle;
   } ptwi_side_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/ptwi_if.sv
// Stream interfaces for twist requests and displacement responses.
interface ptwi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angular_rate;
   logic signed [31:0] linear_x;
   logic signed [31:0] linear_y;
   modport source(output valid, angular_rate, linear_x, linear_y, input ready);
   modport sink(input valid, angular_rate, linear_x, linear_y, output ready);
endinterface

interface ptwi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] disp_x;
   logic signed [31:0] disp_y;
   logic signed [18:0] disp_angle;
   logic               saturated;
   modport source(output valid, disp_x, disp_y, disp_angle, saturated, input ready);
   modport sink(input valid, disp_x, disp_y, disp_angle, saturated, output ready);
endinterface

FILE: hdl/ptwi_wrap.sv
// Angle wrap pipeline: reduces w modulo two pi by one trial subtraction per stage.
module ptwi_wrap (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  ptwi_pkg::ptwi_side_type in_side,
   output logic                    out_valid,
   output ptwi_pkg::ptwi_side_type out_side,
   output logic signed [33:0]      out_angle_q30
);
   import ptwi_pkg::*;

   logic [48:0]   rem_ff  [WRAP_STEPS];
   ptwi_side_type side_ff [WRAP_STEPS];
   logic          vld_ff  [WRAP_STEPS];

   for (genvar i = 0; i < WRAP_STEPS; i++) begin : g_step
      logic [48:0]   rem_prev;
      logic [48:0]   trial;
      logic [48:0]   rem_in;
      ptwi_side_type side_prev;
      logic          vld_prev;
      if (i == 0) begin : g_first
         assign rem_prev  = {1'b0, in_side.mag_w, 16'b0};
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign side_prev = side_ff[i-1];
         assign vld_prev  = vld_ff[i-1];
      end
      assign trial  = 49'(TWO_PI_Q32) << (WRAP_STEPS - 1 - i);
      assign rem_in = (rem_prev >= trial) ? rem_prev - trial : rem_prev;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_prev;
         end
         if (adv) begin
            rem_ff[i]  <= rem_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   logic [34:0]        rem_last;
   logic signed [35:0] m_pos;
   logic signed [35:0] m_in;
   logic signed [35:0] rnd;
   logic signed [35:0] m_ff;
   ptwi_side_type      side_out_in;
   ptwi_side_type      side_out_ff;
   logic               vld_out_ff;

   // C-style remainder keeps the sign of w; fold it back to [0, 2pi), then to (-pi, pi].
   assign rem_last = rem_ff[WRAP_STEPS-1][34:0];
   always_comb begin
      if (side_ff[WRAP_STEPS-1].neg_w && rem_last != 35'd0) begin
         m_pos = $signed(36'(TWO_PI_Q32) - 36'(rem_last));
      end else begin
         m_pos = $signed(36'(rem_last));
      end
      if ({m_pos, 1'b0} > 37'(TWO_PI_Q32)) begin
         m_in = m_pos - $signed(36'(TWO_PI_Q32));
      end else begin
         m_in = m_pos;
      end
      rnd = m_in + 36'sd32768;
      side_out_in       = side_ff[WRAP_STEPS-1];
      side_out_in.angle = rnd[34:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else if (adv) begin
         vld_out_ff <= vld_ff[WRAP_STEPS-1];
      end
      if (adv) begin
         m_ff        <= m_in;
         side_out_ff <= side_out_in;
      end
   end

   assign out_valid     = vld_out_ff;
   assign out_side      = side_out_ff;
   assign out_angle_q30 = m_ff[35:2];
endmodule

FILE: hdl/ptwi_cordic.sv
// Rotation-mode CORDIC pipeline, one micro-rotation per stage, giving cos and sin in Q.30.
module ptwi_cordic #(
   parameter int STAGES = ptwi_pkg::CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  ptwi_pkg::ptwi_side_type in_side,
   input  logic signed [33:0]      in_angle,
   output logic                    out_valid,
   output ptwi_pkg::ptwi_side_type out_side,
   output logic signed [33:0]      out_cos,
   output logic signed [33:0]      out_sin
);
   import ptwi_pkg::*;

   logic signed [33:0] x_ff    [STAGES+1];
   logic signed [33:0] y_ff    [STAGES+1];
   logic signed [33:0] z_ff    [STAGES+1];
   logic               flip_ff [STAGES+1];
   ptwi_side_type      side_ff [STAGES+1];
   logic               vld_ff  [STAGES+1];

   logic signed [33:0] z_pre_in;
   logic               flip_pre_in;

   // Angles beyond a quarter turn are moved by pi; the results are negated at the end.
   always_comb begin
      if (in_angle > HALF_PI_Q30) begin
         z_pre_in    = in_angle - PI_Q30;
         flip_pre_in = 1'b1;
      end else if (in_angle < -HALF_PI_Q30) begin
         z_pre_in    = in_angle + PI_Q30;
         flip_pre_in = 1'b1;
      end else begin
         z_pre_in    = in_angle;
         flip_pre_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_pre_in;
         flip_ff[0] <= flip_pre_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] ang;
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [33:0] z_in;
      assign dx  = y_ff[i] >>> i;
      assign dy  = x_ff[i] >>> i;
      assign ang = $signed({4'b0, atan_q30(5'(i))});
      always_comb begin
         if (z_ff[i] >= 34'sd0) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - ang;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + ang;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (adv) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            flip_ff[i+1] <= flip_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign out_side  = side_ff[STAGES];
   assign out_cos   = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
   assign out_sin   = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
endmodule

FILE: hdl/ptwi_numer.sv
// Numerator pipeline: forms x*sin + y*(cos-1) and y*sin - x*(cos-1) as exact Q.46 values.
module ptwi_numer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  ptwi_pkg::ptwi_side_type in_side,
   input  logic signed [33:0]      in_cos,
   input  logic signed [33:0]      in_sin,
   output logic                    out_valid,
   output ptwi_pkg::ptwi_side_type out_side,
   output logic signed [67:0]      out_num_x,
   output logic signed [67:0]      out_num_y
);
   import ptwi_pkg::*;

   logic signed [34:0] cm1_ff;
   logic signed [33:0] sin_ff;
   ptwi_side_type      side1_ff;
   logic               vld1_ff;

   logic signed [66:0] xs_ff;
   logic signed [66:0] ys_ff;
   logic signed [66:0] xc_ff;
   logic signed [66:0] yc_ff;
   ptwi_side_type      side2_ff;
   logic               vld2_ff;

   logic signed [67:0] nx_ff;
   logic signed [67:0] ny_ff;
   ptwi_side_type      side3_ff;
   logic               vld3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      if (adv) begin
         cm1_ff   <= 35'(in_cos) - 35'(ONE_Q30);
         sin_ff   <= in_sin;
         side1_ff <= in_side;
         xs_ff    <= 67'(side1_ff.lin_x) * 67'(sin_ff);
         ys_ff    <= 67'(side1_ff.lin_y) * 67'(sin_ff);
         xc_ff    <= 67'(side1_ff.lin_x) * 67'(cm1_ff);
         yc_ff    <= 67'(side1_ff.lin_y) * 67'(cm1_ff);
         side2_ff <= side1_ff;
         nx_ff    <= 68'(xs_ff) + 68'(yc_ff);
         ny_ff    <= 68'(ys_ff) - 68'(xc_ff);
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = vld3_ff;
   assign out_side  = side3_ff;
   assign out_num_x = nx_ff;
   assign out_num_y = ny_ff;
endmodule

FILE: hdl/ptwi_div.sv
// Pipelined restoring divider for both axes: rounded, saturated quotient by w*2^14.
module ptwi_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  ptwi_pkg::ptwi_side_type in_side,
   input  logic signed [67:0]      in_num_x,
   input  logic signed [67:0]      in_num_y,
   output logic                    out_valid,
   output ptwi_pkg::ptwi_side_type out_side,
   output logic signed [31:0]      out_quo_x,
   output logic signed [31:0]      out_quo_y,
   output logic                    out_sat
);
   import ptwi_pkg::*;

   logic signed [67:0] num [2];
   assign num[0] = in_num_x;
   assign num[1] = in_num_y;

   // Stage A: sign and magnitude.
   logic [67:0]   mag_ff  [2];
   logic          nega_ff [2];
   ptwi_side_type sidea_ff;
   logic          vlda_ff;

   // Stage B: add half the divisor and check for quotient overflow.
   logic [45:0]   den_a;
   logic [45:0]   remb_ff [2];
   logic [31:0]   lowb_ff [2];
   logic          ovfb_ff [2];
   logic          negb_ff [2];
   ptwi_side_type sideb_ff;
   logic          vldb_ff;

   assign den_a = {sidea_ff.mag_w, 14'b0};

   for (genvar l = 0; l < 2; l++) begin : g_lane_ab
      logic [68:0] sum_in;
      assign sum_in = 69'(mag_ff[l]) + 69'(den_a[45:1]);
      always_ff @(posedge clock) begin
         if (adv) begin
            mag_ff[l]  <= num[l][67] ? 68'(-num[l]) : 68'(num[l]);
            nega_ff[l] <= num[l][67] ^ in_side.neg_w;
            remb_ff[l] <= {9'b0, sum_in[68:32]};
            lowb_ff[l] <= sum_in[31:0];
            ovfb_ff[l] <= {9'b0, sum_in} >= {den_a, 32'b0};
            negb_ff[l] <= nega_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff <= 1'b0;
         vldb_ff <= 1'b0;
      end else if (adv) begin
         vlda_ff <= in_valid;
         vldb_ff <= vlda_ff;
      end
      if (adv) begin
         sidea_ff <= in_side;
         sideb_ff <= sidea_ff;
      end
   end

   // One quotient bit per stage.
   logic [45:0]   rem_ff  [DIV_STEPS][2];
   logic [31:0]   low_ff  [DIV_STEPS][2];
   logic [31:0]   quo_ff  [DIV_STEPS][2];
   logic          ovf_ff  [DIV_STEPS][2];
   logic          neg_ff  [DIV_STEPS][2];
   ptwi_side_type side_ff [DIV_STEPS];
   logic          vld_ff  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      ptwi_side_type side_prev;
      logic          vld_prev;
      logic [45:0]   den;
      if (k == 0) begin : g_first
         assign side_prev = sideb_ff;
         assign vld_prev  = vldb_ff;
      end else begin : g_next
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end
      assign den = {side_prev.mag_w, 14'b0};

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [45:0] rem_prev;
         logic [31:0] low_prev;
         logic [31:0] quo_prev;
         logic        ovf_prev;
         logic        neg_prev;
         logic [46:0] trial;
         logic        ge;
         if (k == 0) begin : g_first
            assign rem_prev = remb_ff[l];
            assign low_prev = lowb_ff[l];
            assign quo_prev = '0;
            assign ovf_prev = ovfb_ff[l];
            assign neg_prev = negb_ff[l];
         end else begin : g_next
            assign rem_prev = rem_ff[k-1][l];
            assign low_prev = low_ff[k-1][l];
            assign quo_prev = quo_ff[k-1][l];
            assign ovf_prev = ovf_ff[k-1][l];
            assign neg_prev = neg_ff[k-1][l];
         end
         assign trial = {rem_prev, low_prev[31]};
         assign ge    = trial >= {1'b0, den};
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][l] <= ge ? 46'(trial - {1'b0, den}) : trial[45:0];
               low_ff[k][l] <= {low_prev[30:0], 1'b0};
               quo_ff[k][l] <= {quo_prev[30:0], ge};
               ovf_ff[k][l] <= ovf_prev;
               neg_ff[k][l] <= neg_prev;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
         if (adv) begin
            side_ff[k] <= side_prev;
         end
      end
   end

   // Final stage: apply sign and clip to the 32-bit range.
   logic signed [31:0] res_ff [2];
   logic               sat_ff [2];
   ptwi_side_type      sidef_ff;
   logic               vldf_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane_f
      logic [31:0] q;
      logic        ng;
      logic        sat_in;
      assign q  = quo_ff[DIV_STEPS-1][l];
      assign ng = neg_ff[DIV_STEPS-1][l];
      assign sat_in = ovf_ff[DIV_STEPS-1][l] || (!ng && q[31]) || (ng && q > 32'h8000_0000);
      always_ff @(posedge clock) begin
         if (adv) begin
            sat_ff[l] <= sat_in;
            if (sat_in) begin
               res_ff[l] <= ng ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
               res_ff[l] <= ng ? $signed(-q) : $signed(q);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldf_ff <= 1'b0;
      end else if (adv) begin
         vldf_ff <= vld_ff[DIV_STEPS-1];
      end
      if (adv) begin
         sidef_ff <= side_ff[DIV_STEPS-1];
      end
   end

   assign out_valid = vldf_ff;
   assign out_side  = sidef_ff;
   assign out_quo_x = res_ff[0];
   assign out_quo_y = res_ff[1];
   assign out_sat   = sat_ff[0] | sat_ff[1];
endmodule

FILE: hdl/planar_twist_integrator_core.sv
// Top level of the planar twist integrator (SE(2) exponential map of a body twist).
//
// req_chan carries one twist (angular_rate, linear_x, linear_y, signed Q16.16) per
// transfer; rsp_chan returns one displacement (disp_x, disp_y, disp_angle, saturated)
// per twist, in order. csr_* writes zero_rate_threshold; csr_ready is always high.
// A twist with |w| below the threshold, or w of zero, is returned as pure translation.
//
// Throughput is one twist per cycle while rsp_chan does not stall. The pipeline is
// 1 input register, 15 angle wrap stages (trial subtractions of 2pi*2^k, then a fold),
// CORDIC_STAGES + 1 CORDIC stages, 3 multiply stages, 35 divider stages (sign, rounding,
// one quotient bit per step stage, sign and clip), 1 output register.
//
// Reset empties the pipeline and sets the threshold to 1. When rsp_chan stalls, the
// whole pipeline holds and req_chan.ready falls in the same cycle; nothing is lost
// or repeated.
module planar_twist_integrator_core #(
   parameter int CORDIC_STAGES = ptwi_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ptwi_req_if.sink    req_chan,
   ptwi_rsp_if.source  rsp_chan,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_wdata
);
   import ptwi_pkg::*;

   logic        adv;
   logic [16:0] thr_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] disp_x_ff;
   logic signed [31:0] disp_y_ff;
   logic signed [18:0] disp_angle_ff;
   logic               saturated_ff;

   // The pipeline moves whenever the output register is free or being drained.
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_ready      = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 17'd1;
      end else if (csr_valid) begin
         thr_ff <= csr_wdata;
      end
   end

   // Input register: magnitude of w and the translation decision.
   logic [31:0]   mag_w;
   ptwi_side_type side_in;
   ptwi_side_type side0_ff;
   logic          vld0_ff;

   assign mag_w = req_chan.angular_rate[31] ? 32'(-req_chan.angular_rate)
                                            : 32'(req_chan.angular_rate);
   always_comb begin
      side_in.bypass = (req_chan.angular_rate == 32'sd0) || (mag_w < 32'(thr_ff));
      side_in.neg_w  = req_chan.angular_rate[31];
      side_in.mag_w  = mag_w;
      side_in.lin_x  = req_chan.linear_x;
      side_in.lin_y  = req_chan.linear_y;
      side_in.angle  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_chan.valid;
      end
      if (adv) begin
         side0_ff <= side_in;
      end
   end

   logic               wrap_valid;
   ptwi_side_type      wrap_side;
   logic signed [33:0] wrap_angle;

   ptwi_wrap u_wrap (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (vld0_ff),
      .in_side       (side0_ff),
      .out_valid     (wrap_valid),
      .out_side      (wrap_side),
      .out_angle_q30 (wrap_angle)
   );

   logic               cor_valid;
   ptwi_side_type      cor_side;
   logic signed [33:0] cor_cos;
   logic signed [33:0] cor_sin;

   ptwi_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (wrap_valid),
      .in_side   (wrap_side),
      .in_angle  (wrap_angle),
      .out_valid (cor_valid),
      .out_side  (cor_side),
      .out_cos   (cor_cos),
      .out_sin   (cor_sin)
   );

   logic               num_valid;
   ptwi_side_type      num_side;
   logic signed [67:0] num_x;
   logic signed [67:0] num_y;

   ptwi_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cor_valid),
      .in_side   (cor_side),
      .in_cos    (cor_cos),
      .in_sin    (cor_sin),
      .out_valid (num_valid),
      .out_side  (num_side),
      .out_num_x (num_x),
      .out_num_y (num_y)
   );

   logic               div_valid;
   ptwi_side_type      div_side;
   logic signed [31:0] quo_x;
   logic signed [31:0] quo_y;
   logic               quo_sat;

   ptwi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (num_valid),
      .in_side   (num_side),
      .in_num_x  (num_x),
      .in_num_y  (num_y),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo_x (quo_x),
      .out_quo_y (quo_y),
      .out_sat   (quo_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
      if (adv) begin
         if (div_side.bypass) begin
            disp_x_ff     <= div_side.lin_x;
            disp_y_ff     <= div_side.lin_y;
            disp_angle_ff <= '0;
            saturated_ff  <= 1'b0;
         end else begin
            disp_x_ff     <= quo_x;
            disp_y_ff     <= quo_y;
            disp_angle_ff <= div_side.angle;
            saturated_ff  <= quo_sat;
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.disp_x     = disp_x_ff;
   assign rsp_chan.disp_y     = disp_y_ff;
   assign rsp_chan.disp_angle = disp_angle_ff;
   assign rsp_chan.saturated  = saturated_ff;
endmodule

FILE: hdl/ptwi_checker.sv
// Port-level assertions for the planar twist integrator, bound to the top level.
module ptwi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] disp_x,
   input logic signed [31:0] disp_y,
   input logic signed [18:0] disp_angle,
   input logic               saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(disp_x) && $stable(disp_y)
         && $stable(disp_angle) && $stable(saturated))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> disp_angle >= -19'sd205887 && disp_angle <= 19'sd205887)
      else $error("rotation outside (-pi, pi]");

   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |-> disp_x == 32'sh7fff_ffff || disp_x == 32'sh8000_0000
         || disp_y == 32'sh7fff_ffff || disp_y == 32'sh8000_0000)
      else $error("saturated flag without a clipped output");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output drain");

endmodule

bind planar_twist_integrator_core ptwi_checker u_ptwi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .disp_x     (rsp_chan.disp_x),
   .disp_y     (rsp_chan.disp_y),
   .disp_angle (rsp_chan.disp_angle),
   .saturated  (rsp_chan.saturated)
);

FILE: dv/testbench.sv
// Self-checking testbench for the planar twist integrator core.
module testbench;
   import ptwi_pkg::*;

   localparam int PIPE_LAT   = CORDIC_STAGES_DEF + 56;
   localparam int STALL_MAX  = 5000;
   localparam int NUM_RANDOM = 1380;

   typedef struct packed {
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [18:0] disp_angle;
      logic               saturated;
   } disp_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] csr_wdata;
   logic        rsp_stall_en;
   int          error_count;
   int          idle_cycles;
   disp_type    expected_disp_q[$];
   logic [16:0] threshold;

   ptwi_req_if req_chan();
   ptwi_rsp_if rsp_chan();

   planar_twist_integrator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   // Rounded division with saturation; den is positive, neg_den gives the sign of w.
   function automatic logic signed [31:0] div_round_sat(longint num, longint unsigned den,
                                                       bit neg_den, inout bit sat);
      bit neg;
      longint unsigned mag, q;
      neg = (num < 0) != neg_den;
      mag = (num < 0) ? longint'(0) - num : num;
      q = (mag + den / 2) / den;
      if (!neg && q > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (neg && q > 64'h8000_0000) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return 32'(neg ? -longint'(q) : longint'(q));
   endfunction

   function automatic disp_type predict_disp(logic signed [31:0] w_in,
                                             logic signed [31:0] x_in,
                                             logic signed [31:0] y_in);
      disp_type d;
      longint w, x, y, m, cx, sy, z, dx, dy, n1, n2, ang;
      longint unsigned aw, den;
      bit flip, sat;
      w = w_in;
      x = x_in;
      y = y_in;
      aw = (w < 0) ? -w : w;
      sat = 1'b0;
      d.disp_angle = '0;
      if (w == 0 || aw < threshold) begin
         d.disp_x = x_in;
         d.disp_y = y_in;
      end else begin
         m = (w * 65536) % longint'(TWO_PI_Q32);
         if (m < 0) m += longint'(TWO_PI_Q32);
         if (2 * m > longint'(TWO_PI_Q32)) m -= longint'(TWO_PI_Q32);
         ang = longint'(longint'(unsigned'(m + 32768 + (64'sd1 <<< 40))) >> 16)
               - (64'sd1 <<< 24);
         d.disp_angle = ang[18:0];
         z = asr(m, 2);
         cx = GAIN_Q30;
         sy = 0;
         flip = 1'b0;
         if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1'b1;
         end else if (z < -longint'(HALF_PI_Q30)) begin
            z += PI_Q30;
            flip = 1'b1;
         end
         for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = asr(sy, i);
            dy = asr(cx, i);
            if (z >= 0) begin
               cx -= dx;
               sy += dy;
               z -= longint'(atan_q30(i[4:0]));
            end else begin
               cx += dx;
               sy -= dy;
               z += longint'(atan_q30(i[4:0]));
            end
         end
         if (flip) begin
            cx = -cx;
            sy = -sy;
         end
         n1 = x * sy + y * (cx - ONE_Q30);
         n2 = x * (ONE_Q30 - cx) + y * sy;
         den = aw << 14;
         d.disp_x = div_round_sat(n1, den, w < 0, sat);
         d.disp_y = div_round_sat(n2, den, w < 0, sat);
      end
      d.saturated = sat;
      return d;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic int random_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Valid stays high between back-to-back transfers and drops only for a gap.
   task automatic send_twist(logic signed [31:0] w, logic signed [31:0] x,
                             logic signed [31:0] y);
      int gap;
      gap = random_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.angular_rate <= w;
      req_chan.linear_x     <= x;
      req_chan.linear_y     <= y;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_disp_q.push_back(predict_disp(w, x, y));
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_disp_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 10) @(posedge clock);
   endtask

   task automatic write_threshold(logic [16:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1: return $signed($urandom_range(0, 400000)) - 200000;
         2: return $signed($urandom_range(0, 20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] random_rate();
      case ($urandom_range(0, 7))
         0: return $signed($urandom_range(0, 6)) - 3;
         1: return $signed($urandom_range(0, 140000)) - 70000;
         2: return $signed($urandom_range(0, 2000000)) - 1000000;
         3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] edge_vals[5];
      edge_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd65536, -32'sd1};
      send_twist(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_twist(1, 100, -100);
      send_twist(-1, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_twist(32'sd205887, 32'sd65536, 32'sd65536);
      send_twist(-32'sd205887, 32'sd65536, -32'sd65536);
      send_twist(32'sd102944, 32'sd65536, 0);
      send_twist(-32'sd102944, 0, 32'sd65536);
      send_twist(32'sd411775, 32'sd65536, 32'sd65536);
      send_twist(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_twist(-2, 32'sh8000_0000, 32'sh8000_0000);
      foreach (edge_vals[i]) send_twist(edge_vals[i], edge_vals[(i + 1) % 5],
                                        edge_vals[(i + 3) % 5]);
      send_twist(32'sd65536, -32'sd1, 32'sd1);
   endtask

   task automatic test_thresholds();
      logic [16:0] settings[4];
      settings = '{17'd0, 17'h1FFFF, 17'd65536, 17'd300};
      foreach (settings[k]) begin
         wait_drained();
         write_threshold(settings[k]);
         send_twist(0, 5, 7);
         send_twist($signed(32'(settings[k])), 32'sd65536, -32'sd65536);
         send_twist(-$signed(32'(settings[k])) + 32'sd1, 32'sd1000, 32'sd2000);
         send_twist($signed(32'(settings[k])) - 32'sd1, 32'sh7FFF_FFFF,
                    32'sh8000_0000);
      end
      wait_drained();
      write_threshold(17'd1);
   endtask

   task automatic test_random();
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM / 2) begin
            // Hold the sender until the pipeline has fully drained.
            wait_drained();
            write_threshold(17'($urandom_range(0, 17'h1FFFF)));
         end
         send_twist(random_rate(), random_word(), random_word());
      end
   endtask

   // Result stall pattern; occasional long stretches with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (!rsp_stall_en) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0) ||
                           ($urandom_range(0, 99) == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && $urandom_range(0, 499) == 0) rsp_stall_en <= !rsp_stall_en;
   end

   always @(posedge clock) begin
      disp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_disp_q.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = expected_disp_q.pop_front();
            if (rsp_chan.disp_x !== want.disp_x)
               report_mismatch("disp_x", rsp_chan.disp_x, want.disp_x);
            if (rsp_chan.disp_y !== want.disp_y)
               report_mismatch("disp_y", rsp_chan.disp_y, want.disp_y);
            if (rsp_chan.disp_angle !== want.disp_angle)
               report_mismatch("disp_angle", rsp_chan.disp_angle, want.disp_angle);
            if (rsp_chan.saturated !== want.saturated)
               report_mismatch("saturated", rsp_chan.saturated, want.saturated);
         end
      end
   end

   // The watchdog restarts on any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("** planar_twist_integrator_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_valid             = 1'b0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.angular_rate = '0;
      req_chan.linear_x     = '0;
      req_chan.linear_y     = '0;
      rsp_stall_en          = 1'b1;
      error_count           = 0;
      idle_cycles           = 0;
      threshold             = 17'd1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_random();
      wait_drained();
      if (error_count == 0) begin
         $display("** planar_twist_integrator_core: PASSED **");
      end else begin
         $display("** planar_twist_integrator_core: FAILED **");
      end
      $finish;
   end

endmodule
